// ===== rtl/bds_pkg.sv =====
// shared types and constants for the box downsampler
package bds_pkg;

  // pixel channel and configuration widths
  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int CFG_W      = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(80);

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // per-item control that travels with a sample into the accumulate stage
  typedef struct packed {
    logic first;    // first sample of a block, replaces the stored sum
    logic emit;     // last sample of a block, produces an output pixel
    logic row_end;  // block sits in the last output column
  } bds_ctl_t;

endpackage

// ===== rtl/bds_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module bds_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bds_accum.sv =====
// column sum read-modify-write stage around the sum memory
module bds_accum #(
  parameter int SCALE     = 4,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          acc_vld,
  input  bds_pkg::bds_ctl_t                             acc_ctl,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] acc_addr,
  input  logic [bds_pkg::RGB_W-1:0]                     acc_pix,
  output logic                                          sum_vld,
  output logic                                          sum_row_end,
  output logic [3*$clog2(255*SCALE*SCALE+1)-1:0]        sum_data
);
  import bds_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SW = $clog2(255 * SCALE * SCALE + 1);
  localparam int DW = 3 * SW;

  logic            vld_r;
  bds_ctl_t        ctl_r;
  logic [AW-1:0]   addr_r;
  logic [RGB_W-1:0] pix_r;
  logic            fwd_r;
  logic [DW-1:0]   fwd_data_r;
  logic [DW-1:0]   rdata;
  logic [DW-1:0]   old_sums;
  logic [DW-1:0]   new_sums;

  bds_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (vld_r),
    .waddr (addr_r),
    .wdata (new_sums),
    .re    (acc_vld),
    .raddr (acc_addr),
    .rdata (rdata)
  );

  // a read that lands on the entry being written takes the new sum instead
  assign old_sums = fwd_r ? fwd_data_r : rdata;

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic [SW-1:0] smp;
    assign smp = SW'(pix_r[ch*PIX_W +: PIX_W]);
    assign new_sums[ch*SW +: SW] = ctl_r.first ? smp : (old_sums[ch*SW +: SW] + smp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      vld_r <= acc_vld;
      fwd_r <= vld_r && (addr_r == acc_addr);
    end
  end

  always_ff @(posedge clk) begin
    ctl_r      <= acc_ctl;
    addr_r     <= acc_addr;
    pix_r      <= acc_pix;
    fwd_data_r <= new_sums;
  end

  assign sum_vld     = vld_r && ctl_r.emit;
  assign sum_row_end = ctl_r.row_end;
  assign sum_data    = new_sums;

endmodule

// ===== rtl/bds_divide.sv =====
// divide block sums by scale squared with an exact reciprocal multiply
module bds_divide #(
  parameter int SCALE = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_vld,
  input  logic                                   in_row_end,
  input  logic [3*$clog2(255*SCALE*SCALE+1)-1:0] in_sums,
  output logic                                   div_vld,
  output logic                                   div_row_end,
  output logic [bds_pkg::RGB_W-1:0]              div_pix
);
  import bds_pkg::*;

  localparam int SW = $clog2(255 * SCALE * SCALE + 1);
  localparam int D  = SCALE * SCALE;
  localparam int L  = $clog2(D);
  localparam int K  = SW + L;
  localparam int MW = SW + 1;
  localparam int PW = SW + MW;
  localparam longint unsigned M_VAL = ((64'd1 << K) + D - 1) / D;
  localparam logic [MW-1:0] RECIP = MW'(M_VAL);

  logic              a_vld_r;
  logic              a_row_r;
  logic [3*SW-1:0]   a_sums_r;
  logic              b_vld_r;
  logic              b_row_r;
  logic [PW-1:0]     b_prod_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_row_r  <= in_row_end;
    a_sums_r <= in_sums;
    b_row_r  <= a_row_r;
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    always_ff @(posedge clk) begin
      b_prod_r[ch] <= PW'(a_sums_r[ch*SW +: SW]) * PW'(RECIP);
    end
    // quotient never exceeds the pixel range
    assign div_pix[ch*PIX_W +: PIX_W] = b_prod_r[ch][K +: PIX_W];
  end

  assign div_vld     = b_vld_r;
  assign div_row_end = b_row_r;

endmodule

// ===== rtl/bds_out_fifo.sv =====
// small result queue in front of the output channel
module bds_out_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic [bds_pkg::RGB_W:0]   push_data,
  input  logic                      pop,
  output logic                      head_vld,
  output logic [bds_pkg::RGB_W:0]   head_data
);
  import bds_pkg::*;

  logic [RGB_W:0]       slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_CW-1:0]   cnt_r;
  logic                 do_pop;

  assign head_vld  = (cnt_r != '0);
  assign head_data = slot_r[rd_ptr_r];
  assign do_pop    = pop && head_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + FIFO_CW'(push) - FIFO_CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/box_downsample_supersampled_pixels.sv =====
// top level of the box-filter downsampler for supersampled rgb streams
// pipeline: an item that closes a block shows its pixel after the accumulate/write-back
//   with sum register, the divider sum and product registers, and the queue write
// throughput: one item per cycle; the sum memory read-modify-write forwards
//   back-to-back hits on the same column; input stalls while 4 results are pending
// reset: rst_n is synchronous, active low; clears counters, queue and width (80)
// column sums are not cleared: each block overwrites its entry on its first sample
module box_downsample_supersampled_pixels #(
  parameter int SCALE     = 4,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration: output pixels per row
  input  logic                        cfg_we,
  input  logic [bds_pkg::CFG_W-1:0]   cfg_wdata,
  // input samples
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [bds_pkg::RGB_W-1:0]   in_tdata,   // red_in, green_in, blue_in
  // output pixels
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [bds_pkg::RGB_W-1:0]   out_tdata,  // red_out, green_out, blue_out
  output logic                        out_tlast   // row_end
);
  import bds_pkg::*;

  localparam int SBW = $clog2(SCALE);
  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SW  = $clog2(255 * SCALE * SCALE + 1);
  localparam int WW  = ((CFG_W > CW) ? CFG_W : CW) + 1;
  localparam logic [SBW-1:0] SUB_LAST = SBW'(SCALE - 1);
  localparam logic [WW-1:0]  MAXW     = WW'(MAX_WIDTH);

  // configuration and position counters
  logic [CFG_W-1:0]   out_width_r;
  logic [CW-1:0]      out_col_r, out_col_nxt;
  logic [SBW-1:0]     sub_col_r, sub_col_nxt;
  logic [SBW-1:0]     sub_row_r, sub_row_nxt;
  // results accepted but not yet delivered, bounds the queue
  logic [FIFO_CW-1:0] pend_r, pend_nxt;

  logic               in_acc;
  logic               out_acc;
  logic [WW-1:0]      width_ext;
  logic [WW-1:0]      last_col_idx;
  logic               last_col;
  bds_ctl_t           ctl;

  logic               sum_vld;
  logic               sum_row_end;
  logic [3*SW-1:0]    sum_data;
  logic               div_vld;
  logic               div_row_end;
  logic [RGB_W-1:0]   div_pix;
  logic [RGB_W:0]     head_data;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // room for one more result in the queue, whether or not this item makes one
  assign in_tready = (pend_r < FIFO_CW'(FIFO_DEPTH));

  // last column index of the clamped width; zero width acts as one column
  assign width_ext = WW'(out_width_r);
  always_comb begin
    priority if (width_ext == '0) begin
      last_col_idx = '0;
    end else if (width_ext > MAXW) begin
      last_col_idx = MAXW - 1'b1;
    end else begin
      last_col_idx = width_ext - 1'b1;
    end
  end

  // a column at or past the end (after a width shrink) counts as the last
  assign last_col = (WW'(out_col_r) >= last_col_idx);

  assign ctl.first   = (sub_row_r == '0) && (sub_col_r == '0);
  assign ctl.emit    = (sub_row_r == SUB_LAST) && (sub_col_r == SUB_LAST);
  assign ctl.row_end = last_col;

  // raster walk: sub column, then output column, then sub row of the band
  always_comb begin
    out_col_nxt = out_col_r;
    sub_col_nxt = sub_col_r;
    sub_row_nxt = sub_row_r;
    if (in_acc) begin
      if (sub_col_r >= SUB_LAST) begin
        sub_col_nxt = '0;
        if (last_col) begin
          out_col_nxt = '0;
          sub_row_nxt = (sub_row_r >= SUB_LAST) ? '0 : (sub_row_r + 1'b1);
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end else begin
        sub_col_nxt = sub_col_r + 1'b1;
      end
    end
  end

  assign pend_nxt = pend_r + FIFO_CW'(in_acc && ctl.emit) - FIFO_CW'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_width_r <= CFG_RESET;
      out_col_r   <= '0;
      sub_col_r   <= '0;
      sub_row_r   <= '0;
      pend_r      <= '0;
    end else begin
      if (cfg_we) begin
        out_width_r <= cfg_wdata;
      end
      out_col_r <= out_col_nxt;
      sub_col_r <= sub_col_nxt;
      sub_row_r <= sub_row_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // per-column running sums in memory
  bds_accum #(
    .SCALE     (SCALE),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc_vld     (in_acc),
    .acc_ctl     (ctl),
    .acc_addr    (out_col_r),
    .acc_pix     (in_tdata),
    .sum_vld     (sum_vld),
    .sum_row_end (sum_row_end),
    .sum_data    (sum_data)
  );

  // block average
  bds_divide #(
    .SCALE (SCALE)
  ) u_divide (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (sum_vld),
    .in_row_end  (sum_row_end),
    .in_sums     (sum_data),
    .div_vld     (div_vld),
    .div_row_end (div_row_end),
    .div_pix     (div_pix)
  );

  // output queue decouples the pipeline from the consumer
  bds_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (div_vld),
    .push_data ({div_row_end, div_pix}),
    .pop       (out_tready),
    .head_vld  (out_tvalid),
    .head_data (head_data)
  );

  assign out_tdata = head_data[RGB_W-1:0];
  assign out_tlast = head_data[RGB_W];

  // pending results never exceed the queue depth
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("pending result count above queue depth");

  // a pixel on the output always has a pending result behind it
  a_out_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pend_r != '0))
    else $error("output valid with no pending result");

  // sub-block counters stay inside the block
  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sub_col_r <= SUB_LAST) && (sub_row_r <= SUB_LAST))
    else $error("sub-block counter out of range");

  // an accepted item that closes a block reaches the output queue
  a_emit_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ctl.emit) |-> ##3 div_vld)
    else $error("block result lost in the pipeline");

endmodule
